// ===== src/stev_pkg.sv =====
package stev_pkg;

	// configuration register indexes
	localparam logic REG_MAX_VOLUME = 1'b0;
	localparam logic REG_FADE_FRAMES = 1'b1;

	localparam logic [4:0] VOL_LIMIT = 5'd20;
	localparam logic [7:0] GAIN_LIMIT = 8'd100;

	// floor(x / 100) = (x * RECIP_100) >> RECIP_SHIFT for x below 2^20
	localparam logic [20:0] RECIP_100 = 21'd1342178;
	localparam int RECIP_SHIFT = 27;

	localparam int DIV_STEPS = 5;

	// item state carried down the pipeline
	typedef struct packed {
		logic live;
		logic neg;
		logic [14:0] mag;
		logic [6:0] gain;
		logic [4:0] peak;
		logic [15:0] fade;
		logic use_up;
		logic use_dn;
		logic [20:0] rem_up;
		logic [20:0] rem_dn;
		logic [4:0] q_up;
		logic [4:0] q_dn;
	} pipe_t;

	// magnitude of the 32-entry full-cycle sine table
	function automatic logic [14:0] sine_mag(input logic [4:0] idx);
		logic [14:0] m;
		case (idx[3:0])
			4'd0: m = 15'd0;
			4'd1, 4'd15: m = 15'd6393;
			4'd2, 4'd14: m = 15'd12539;
			4'd3, 4'd13: m = 15'd18204;
			4'd4, 4'd12: m = 15'd23170;
			4'd5, 4'd11: m = 15'd27245;
			4'd6, 4'd10: m = 15'd30273;
			4'd7, 4'd9: m = 15'd32137;
			default: m = 15'd32767;
		endcase
		return m;
	endfunction

endpackage

// ===== src/stev_div.sv =====
module stev_div
	import stev_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input pipe_t in_data,
	output logic out_valid,
	output pipe_t out_data
);

	pipe_t div_s [0:DIV_STEPS-1];
	logic div_vld_s [0:DIV_STEPS-1];
	pipe_t nx [0:DIV_STEPS-1];

	// one restoring step on both ramps, quotient bit b
	function automatic pipe_t div_step(input pipe_t p, input logic [2:0] b);
		pipe_t r;
		logic [21:0] dv;
		r = p;
		dv = {6'd0, p.fade} << b;
		if ({1'b0, p.rem_up} >= dv) begin
			r.rem_up = p.rem_up - dv[20:0];
			r.q_up[b] = 1'b1;
		end
		if ({1'b0, p.rem_dn} >= dv) begin
			r.rem_dn = p.rem_dn - dv[20:0];
			r.q_dn[b] = 1'b1;
		end
		return r;
	endfunction

	// next value of every step, most significant bit first
	always_comb begin
		for (int j = 0; j < DIV_STEPS; j++) begin
			if (j == 0) begin
				nx[j] = div_step(in_data, 3'(DIV_STEPS - 1));
			end else begin
				nx[j] = div_step(div_s[j-1], 3'(DIV_STEPS - 1 - j));
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (en) begin
			for (int j = 0; j < DIV_STEPS; j++) begin
				div_s[j] <= nx[j];
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < DIV_STEPS; j++) begin
				div_vld_s[j] <= 1'b0;
			end
		end else if (en) begin
			div_vld_s[0] <= in_valid;
			for (int j = 1; j < DIV_STEPS; j++) begin
				div_vld_s[j] <= div_vld_s[j-1];
			end
		end
	end

	assign out_valid = div_vld_s[DIV_STEPS-1];
	assign out_data = div_s[DIV_STEPS-1];

endmodule

// ===== src/stev_scale.sv =====
module stev_scale
	import stev_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic in_valid,
	input pipe_t in_data,
	output logic out_valid,
	output logic [15:0] out_sample
);

	logic [4:0] vol;
	logic [19:0] prod1_s1;
	logic [6:0] gain_s1, gain_s2;
	logic live_s1, live_s2, live_s3;
	logic neg_s1, neg_s2, neg_s3;
	logic [40:0] t1;
	logic [12:0] q1_s2;
	logic [19:0] prod2_s3;
	logic [40:0] t2;
	logic [12:0] q2;
	logic [15:0] sample_s4;
	logic vld_s1, vld_s2, vld_s3, vld_s4;

	// smaller of the two ramps, peak when neither applies
	always_comb begin
		vol = in_data.peak;
		if (in_data.use_up) begin
			vol = in_data.q_up;
		end
		if (in_data.use_dn && (in_data.q_dn < vol)) begin
			vol = in_data.q_dn;
		end
	end

	assign t1 = 41'(prod1_s1) * 41'(RECIP_100);
	assign t2 = 41'(prod2_s3) * 41'(RECIP_100);
	assign q2 = t2[RECIP_SHIFT+12:RECIP_SHIFT];

	// envelope multiply, divide by 100, gain multiply, divide by 100
	always_ff @(posedge clk) begin
		if (en) begin
			prod1_s1 <= 20'(in_data.mag) * 20'(vol);
			gain_s1 <= in_data.gain;
			live_s1 <= in_data.live;
			neg_s1 <= in_data.neg;
			q1_s2 <= t1[RECIP_SHIFT+12:RECIP_SHIFT];
			gain_s2 <= gain_s1;
			live_s2 <= live_s1;
			neg_s2 <= neg_s1;
			prod2_s3 <= 20'(q1_s2) * 20'(gain_s2);
			live_s3 <= live_s2;
			neg_s3 <= neg_s2;
			if (!live_s3) begin
				sample_s4 <= 16'd0;
			end else if (neg_s3) begin
				sample_s4 <= 16'd0 - 16'(q2);
			end else begin
				sample_s4 <= 16'(q2);
			end
		end
	end

	// valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
		end else if (en) begin
			vld_s1 <= in_valid;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			vld_s4 <= vld_s3;
		end
	end

	assign out_valid = vld_s4;
	assign out_sample = sample_s4;

endmodule

// ===== src/sine_tone_envelope_sample.sv =====
// sine tone sample with linear fade envelope and percent gain
//
// input stream: one beat per sample, s_tdata carries the sample position,
// tone length, phase and gain in percent. output stream: one beat with the
// signed 16-bit sample for each input beat, in order.
// configuration: cfg_we writes cfg_wdata into register cfg_addr
// (0 = max volume percent, 1 = fade frames); write only while idle.
//
// input beat to output beat passes one front stage (table, ramp
// products, compares), five divide steps of the ramp quotients, four
// scaling stages. one beat is taken every cycle unless the output stalls.
//
// reset clears all valid bits and loads max volume 20 and fade 160.
// when the receiver stalls, the whole pipeline holds and s_tready drops;
// s_tready is high whenever the output register is empty or being taken.
module sine_tone_envelope_sample
	import stev_pkg::*;
#(
	parameter int COUNT_WIDTH = 24
) (
	input logic clk,
	input logic arst_n,
	input logic s_tvalid,
	output logic s_tready,
	// position[CW-1:0], length[CW-1:0], phase[31:0], gain[7:0], zero fill
	input logic [((2*COUNT_WIDTH+40+7)/8)*8-1:0] s_tdata,
	output logic m_tvalid,
	input logic m_tready,
	// sample_out[15:0]
	output logic [15:0] m_tdata,
	input logic cfg_we,
	input logic cfg_addr,
	input logic [15:0] cfg_wdata
);

	localparam int CW = COUNT_WIDTH;

	logic [4:0] max_vol_q;
	logic [15:0] fade_q;
	logic en;
	logic [CW-1:0] idx, total, rem, fade_ext;
	logic [31:0] phase;
	logic [7:0] gain_in;
	logic [4:0] peak;
	pipe_t front;
	pipe_t front_s1;
	logic front_vld_s1;
	pipe_t div_out;
	logic div_vld;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_vol_q <= VOL_LIMIT;
			fade_q <= 16'd160;
		end else if (cfg_we) begin
			unique case (cfg_addr)
				REG_MAX_VOLUME: max_vol_q <= cfg_wdata[4:0];
				REG_FADE_FRAMES: fade_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign en = !m_tvalid || m_tready;
	assign s_tready = en;

	assign idx = s_tdata[CW-1:0];
	assign total = s_tdata[2*CW-1:CW];
	assign phase = s_tdata[2*CW+31:2*CW];
	assign gain_in = s_tdata[2*CW+39:2*CW+32];
	assign rem = total - idx - CW'(1);
	assign fade_ext = CW'(fade_q);
	assign peak = (max_vol_q > VOL_LIMIT) ? VOL_LIMIT : max_vol_q;

	// front stage: table lookup, ramp numerators and ramp selection
	always_comb begin
		front.live = idx < total;
		front.neg = phase[31];
		front.mag = sine_mag(phase[31:27]);
		front.gain = (gain_in > GAIN_LIMIT) ? GAIN_LIMIT[6:0] : gain_in[6:0];
		front.peak = peak;
		front.fade = fade_q;
		front.use_up = idx < fade_ext;
		front.use_dn = rem < fade_ext;
		front.rem_up = 21'(peak) * 21'(idx[15:0]);
		front.rem_dn = 21'(peak) * 21'(rem[15:0]);
		front.q_up = 5'd0;
		front.q_dn = 5'd0;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			front_s1 <= front;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_vld_s1 <= 1'b0;
		end else if (en) begin
			front_vld_s1 <= s_tvalid;
		end
	end

	stev_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(front_vld_s1),
		.in_data(front_s1),
		.out_valid(div_vld),
		.out_data(div_out)
	);

	stev_scale u_scale (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.in_valid(div_vld),
		.in_data(div_out),
		.out_valid(m_tvalid),
		.out_sample(m_tdata)
	);

endmodule

// ===== src/stev_chk.sv =====
module stev_chk (
	input logic clk,
	input logic arst_n,
	input logic s_tready,
	input logic m_tvalid,
	input logic m_tready,
	input logic [15:0] m_tdata
);

	// stalled output beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
		else $error("output beat changed while stalled");

	// input side stops exactly while the output is stalled
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tready == (!m_tvalid || m_tready))
		else $error("input ready does not follow output stall");

	// with peak volume at most 20 percent the sample stays within +-6553
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> ($signed(m_tdata) <= 16'sd6553 && $signed(m_tdata) >= -16'sd6553))
		else $error("sample out of range");

	// nothing comes out in the cycle after reset
	a_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_tvalid)
		else $error("output valid right after reset");

endmodule

bind sine_tone_envelope_sample stev_chk u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.s_tready(s_tready),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata(m_tdata)
);

// ===== bench/sine_tone_envelope_sample_tb.sv =====
`timescale 1ns / 100ps

module sine_tone_envelope_sample_tb;
	import stev_pkg::*;

	localparam int CW = 24;
	localparam int DW = ((2*CW+40+7)/8)*8;
	localparam int LATENCY = 10;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [7:0] gain;
		logic [31:0] phase;
		logic [CW-1:0] total;
		logic [CW-1:0] idx;
	} tone_req_t;

	logic clk;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	logic [DW-1:0] s_tdata;
	logic m_tvalid;
	logic m_tready;
	logic [15:0] m_tdata;
	logic cfg_we;
	logic cfg_addr;
	logic [15:0] cfg_wdata;

	// bench copy of the registers
	logic [4:0] vol_reg;
	logic [15:0] fade_reg;

	tone_req_t req_q[$];
	logic [15:0] sample_q[$];
	int err_count;
	int cycles;
	int in_gap;
	int out_gap;
	bit hold_input;

	sine_tone_envelope_sample #(.COUNT_WIDTH(CW)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int sine_value(input logic [4:0] k);
		int tbl[16] = '{0, 6393, 12539, 18204, 23170, 27245, 30273, 32137,
			32767, 32137, 30273, 27245, 23170, 18204, 12539, 6393};
		return k[4] ? -tbl[k[3:0]] : tbl[k[3:0]];
	endfunction

	// expected tone sample for one request
	function automatic logic [15:0] tone_sample(input tone_req_t r);
		longint unsigned peak, vol, rem, dn, g;
		int s;
		peak = (vol_reg > VOL_LIMIT) ? VOL_LIMIT : vol_reg;
		g = (r.gain > GAIN_LIMIT) ? GAIN_LIMIT : r.gain;
		if (r.idx >= r.total) return 16'd0;
		vol = peak;
		if (fade_reg != 0) begin
			if (r.idx < fade_reg) vol = (peak * r.idx) / fade_reg;
			rem = r.total - r.idx - 1;
			if (rem < fade_reg) begin
				dn = (peak * rem) / fade_reg;
				if (dn < vol) vol = dn;
			end
		end
		s = (sine_value(r.phase[31:27]) * int'(vol)) / 100;
		s = (s * int'(g)) / 100;
		return s[15:0];
	endfunction

	function automatic int rand_gap();
		if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
		if ($urandom_range(0, 2) == 0) return 0;
		return $urandom_range(0, 3);
	endfunction

	// input driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
			in_gap <= 0;
		end else begin
			if (!s_tvalid || s_tready) begin
				if (s_tvalid && s_tready)
					sample_q.push_back(tone_sample(tone_req_t'(s_tdata[2*CW+39:0])));
				if (in_gap > 0 || hold_input || req_q.size() == 0) begin
					s_tvalid <= 1'b0;
					if (in_gap > 0) in_gap <= in_gap - 1;
				end else begin
					s_tvalid <= 1'b1;
					s_tdata <= DW'(req_q.pop_front());
					in_gap <= rand_gap();
				end
			end
		end
	end

	// output monitor and receiver stalls
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			out_gap <= 0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (sample_q.size() == 0) begin
					err_count++;
					if (err_count <= 10) $display("unexpected sample %0d", $signed(m_tdata));
				end else begin
					if (m_tdata !== sample_q[0]) begin
						err_count++;
						if (err_count <= 10)
							$display("sample mismatch: expected %0d actual %0d",
								$signed(sample_q[0]), $signed(m_tdata));
					end
					void'(sample_q.pop_front());
				end
			end
			if (out_gap > 0) begin
				m_tready <= 1'b0;
				out_gap <= out_gap - 1;
			end else begin
				m_tready <= 1'b1;
				if ($urandom_range(0, 3) == 0) out_gap <= rand_gap();
			end
		end
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	task automatic wait_drained();
		while (req_q.size() != 0 || s_tvalid || sample_q.size() != 0) @(posedge clk);
		repeat (LATENCY + 2) @(posedge clk);
	endtask

	task automatic write_reg(input logic addr, input logic [15:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= addr;
		cfg_wdata <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (addr == REG_MAX_VOLUME) vol_reg = val[4:0];
		else fade_reg = val;
	endtask

	function automatic tone_req_t mk(input int unsigned i, input int unsigned t,
		input int unsigned p, input int unsigned g);
		tone_req_t r;
		r.idx = CW'(i); r.total = CW'(t); r.phase = p; r.gain = 8'(g);
		return r;
	endfunction

	// mostly realistic tones with some fully random beats
	task automatic add_random(input int n);
		tone_req_t r;
		int unsigned t;
		for (int k = 0; k < n; k++) begin
			if ($urandom_range(0, 4) == 0) begin
				r.idx = CW'($urandom); r.total = CW'($urandom);
				if ($urandom_range(0, 1)) r.total = 24'hFFFFFF;
				if ($urandom_range(0, 3) == 0) r.idx = 0;
			end else begin
				t = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(1, 2000);
				t &= 24'hFFFFFF;
				if (t == 0) t = 1;
				r.total = CW'(t);
				case ($urandom_range(0, 3))
					0: r.idx = CW'($urandom_range(0, (t < 400) ? t : 400));
					1: r.idx = CW'(t - 1 - $urandom_range(0, (t < 400) ? t - 1 : 400));
					default: r.idx = CW'($urandom_range(0, t));
				endcase
			end
			r.phase = $urandom;
			r.gain = 8'($urandom_range(0, 1) ? $urandom_range(0, 255)
				: $urandom_range(90, 110));
			req_q.push_back(r);
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = REG_MAX_VOLUME;
		cfg_wdata = '0;
		hold_input = 1'b0;
		err_count = 0;
		cycles = 0;
		vol_reg = 5'd20;
		fade_reg = 16'd160;
		repeat (12) @(posedge clk);
		arst_n = 1'b1;

		// directed: reset settings, extremes, past end, ramps, saturation
		req_q.push_back(mk(0, 0, 32'h4000_0000, 100));
		req_q.push_back(mk(5, 5, 32'h4000_0000, 100));
		req_q.push_back(mk(24'hFFFFFF, 24'hFFFFFF, 32'hFFFF_FFFF, 255));
		req_q.push_back(mk(24'hFFFFFE, 24'hFFFFFF, 32'hC000_0000, 255));
		req_q.push_back(mk(0, 1000, 32'h4000_0000, 100));
		req_q.push_back(mk(80, 1000, 32'h4000_0000, 100));
		req_q.push_back(mk(159, 1000, 32'h4000_0000, 100));
		req_q.push_back(mk(500, 1000, 32'h4000_0000, 101));
		req_q.push_back(mk(999, 1000, 32'hC000_0000, 100));
		req_q.push_back(mk(900, 1000, 32'hC000_0000, 0));
		req_q.push_back(mk(50, 100, 32'h4000_0000, 255));
		for (int k = 0; k < 32; k += 4)
			req_q.push_back(mk(300, 1000, k << 27 | 32'h07FF_FFFF, 100));
		wait_drained();

		// fading off, volume saturation, single-sample fade
		write_reg(REG_FADE_FRAMES, 16'd0);
		write_reg(REG_MAX_VOLUME, 16'd31);
		req_q.push_back(mk(0, 1, 32'h4000_0000, 100));
		req_q.push_back(mk(0, 24'hFFFFFF, 32'hC000_0000, 100));
		add_random(200);
		wait_drained();
		write_reg(REG_FADE_FRAMES, 16'd1);
		write_reg(REG_MAX_VOLUME, 16'd0);
		add_random(150);
		wait_drained();
		write_reg(REG_FADE_FRAMES, 16'hFFFF);
		write_reg(REG_MAX_VOLUME, 16'd20);
		req_q.push_back(mk(65534, 24'hFFFFFF, 32'h4000_0000, 100));
		add_random(150);
		wait_drained();
		write_reg(REG_FADE_FRAMES, 16'd160);
		write_reg(REG_MAX_VOLUME, 16'd13);
		add_random(300);
		// hold input back until every beat already sent has come out
		hold_input = 1'b1;
		while (s_tvalid || sample_q.size() != 0) @(posedge clk);
		hold_input = 1'b0;
		wait_drained();
		write_reg(REG_FADE_FRAMES, 16'd37);
		write_reg(REG_MAX_VOLUME, 16'd21);
		add_random(300);
		wait_drained();

		if (err_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
